// ----- rtl/bsle_pkg.sv -----
package bsle_pkg;

    localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [3:0] OP_POP_FRONT  = 4'd2;
    localparam logic [3:0] OP_POP_BACK   = 4'd3;
    localparam logic [3:0] OP_READ       = 4'd4;
    localparam logic [3:0] OP_WRITE      = 4'd5;
    localparam logic [3:0] OP_FIND_EQ    = 4'd6;
    localparam logic [3:0] OP_FIND_GT    = 4'd7;
    localparam logic [3:0] OP_SORT_INS   = 4'd8;
    localparam logic [3:0] OP_CLEAR      = 4'd9;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam int OP_W     = 4;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 6;
    localparam int LEN_W    = 7;

endpackage

// ----- rtl/bsle_ram.sv -----
module bsle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bounded_sequence_list_engine.sv -----
// Channel | Direction | Handshake    | Payload
// in      | input     | valid, stall | operation, position, operand
// out     | output    | valid, stall | status, read_value, found, found_index, length
//
// One word at a time. Pop and read wait on a registered store read (S_RDWAIT).
// Searches read the store one entry per cycle, up to count entries.
// Sorted insert appends the word, then exchange-sorts the list, swapping when
// element i > element j (signed). The single-port-read store sets the pace.
// rst_n clears head, count and control; store contents are not cleared.
// The result sits in an output register; a new word is taken only after the
// result has been taken.
module bounded_sequence_list_engine #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  operation,
    input  logic [6:0]  position,
    input  logic [31:0] operand,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] read_value,
    output logic        found,
    output logic [5:0]  found_index,
    output logic [6:0]  length
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDWAIT = 4'd1;
    localparam logic [3:0] S_SRCH   = 4'd3;
    localparam logic [3:0] S_SRCHD  = 4'd4;
    localparam logic [3:0] S_SRTA   = 4'd5;
    localparam logic [3:0] S_SRTB   = 4'd6;
    localparam logic [3:0] S_SRTC   = 4'd7;
    localparam logic [3:0] S_SRTW   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    op_reg, op_next;
    logic [31:0]   val_reg, val_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [31:0]   a_reg, a_next;
    logic [1:0]    st_reg, st_next;
    logic [31:0]   rd_reg, rd_next;
    logic          fnd_reg, fnd_next;
    logic [5:0]    fidx_reg, fidx_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    bsle_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    // slot of list index: (head + idx) mod DEPTH, idx < DEPTH
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] idx);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, h} + {1'b0, idx};
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign status     = st_reg;
    assign read_value = rd_reg;
    assign found      = fnd_reg;
    assign found_index = fidx_reg;
    assign length     = 7'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        a_next     = a_reg;
        st_next    = st_reg;
        rd_next    = rd_reg;
        fnd_next   = fnd_reg;
        fidx_next  = fidx_reg;
        we    = 1'b0;
        waddr = '0;
        wdata = val_reg;
        raddr = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = operation;
                    val_next  = operand;
                    st_next   = bsle_pkg::ST_OK;
                    rd_next   = '0;
                    fnd_next  = 1'b0;
                    fidx_next = '0;
                    i_next    = '0;
                    state_next = S_OUT;
                    case (operation)
                        bsle_pkg::OP_PUSH_FRONT, bsle_pkg::OP_PUSH_BACK,
                        bsle_pkg::OP_SORT_INS:
                        begin
                            if (count_reg >= CW'(DEPTH))
                            begin
                                st_next = bsle_pkg::ST_FULL;
                            end
                            else if (operation == bsle_pkg::OP_PUSH_FRONT)
                            begin
                                // head steps back one slot, wrapping below zero
                                head_next = (head_reg == '0) ? AW'(DEPTH - 1)
                                            : head_reg - AW'(1);
                                we = 1'b1;
                                waddr = head_next;
                                wdata = operand;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                we = 1'b1;
                                waddr = slot(head_reg, count_reg);
                                wdata = operand;
                                count_next = count_reg + CW'(1);
                                if (operation == bsle_pkg::OP_SORT_INS)
                                begin
                                    i_next = '0;
                                    state_next = S_SRTA;
                                end
                            end
                        end
                        bsle_pkg::OP_POP_FRONT, bsle_pkg::OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = bsle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                raddr = (operation == bsle_pkg::OP_POP_FRONT) ? head_reg
                                        : slot(head_reg, count_reg - CW'(1));
                                if (operation == bsle_pkg::OP_POP_FRONT)
                                begin
                                    head_next = slot(head_reg, CW'(1));
                                end
                                count_next = count_reg - CW'(1);
                                state_next = S_RDWAIT;
                            end
                        end
                        bsle_pkg::OP_READ, bsle_pkg::OP_WRITE:
                        begin
                            if (32'(position) >= 32'(count_reg))
                            begin
                                st_next = bsle_pkg::ST_RANGE;
                            end
                            else if (operation == bsle_pkg::OP_READ)
                            begin
                                raddr = slot(head_reg, CW'(position));
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                we = 1'b1;
                                waddr = slot(head_reg, CW'(position));
                                wdata = operand;
                            end
                        end
                        bsle_pkg::OP_FIND_EQ, bsle_pkg::OP_FIND_GT:
                        begin
                            if (count_reg != '0)
                            begin
                                raddr = head_reg;
                                state_next = S_SRCH;
                            end
                        end
                        bsle_pkg::OP_CLEAR:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = bsle_pkg::ST_EMPTY;
                            end
                            count_next = '0;
                            head_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                rd_next = rdata;
                state_next = S_OUT;
            end
            S_SRCH:
            begin
                // rdata holds element i
                if ((op_reg == bsle_pkg::OP_FIND_EQ && rdata == val_reg)
                    || (op_reg == bsle_pkg::OP_FIND_GT && $signed(rdata) > $signed(val_reg)))
                begin
                    fnd_next  = 1'b1;
                    fidx_next = 6'(i_reg);
                    state_next = S_OUT;
                end
                else if (i_reg + CW'(1) >= count_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    raddr = slot(head_reg, i_reg + CW'(1));
                end
            end
            S_SRTA:
            begin
                // start row i: read a = element i
                if (i_reg + CW'(1) >= count_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    raddr  = slot(head_reg, i_reg);
                    j_next = i_reg + CW'(1);
                    state_next = S_SRTB;
                end
            end
            S_SRTB:
            begin
                a_next = rdata;
                raddr  = slot(head_reg, j_reg);
                state_next = S_SRTC;
            end
            S_SRTC:
            begin
                // a_reg is current element i (kept up to date), rdata element j
                state_next = S_SRTW;
                if ($signed(a_reg) > $signed(rdata))
                begin
                    we = 1'b1;
                    waddr = slot(head_reg, i_reg);
                    wdata = rdata;
                    a_next = rdata;
                    val_next = a_reg;
                end
                else
                begin
                    state_next = S_SRCHD;
                end
            end
            S_SRTW:
            begin
                we = 1'b1;
                waddr = slot(head_reg, j_reg);
                wdata = val_reg;
                state_next = S_SRCHD;
            end
            S_SRCHD:
            begin
                // advance j, or next row
                if (j_reg + CW'(1) >= count_reg)
                begin
                    i_next = i_reg + CW'(1);
                    state_next = S_SRTA;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                    raddr  = slot(head_reg, j_reg + CW'(1));
                    state_next = S_SRTC;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        val_reg  <= val_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        a_reg    <= a_next;
        st_reg   <= st_next;
        rd_reg   <= rd_next;
        fnd_reg  <= fnd_next;
        fidx_reg <= fidx_next;
    end

endmodule
